[rtl/dspw_pkg.sv]
`default_nettype none

package dspw_pkg;

   localparam int unsigned VALUE_W = 14;
   localparam logic [VALUE_W-1:0] VALUE_MAX = 14'd16383;

   localparam logic [7:0] CHAR_DOT  = 8'h2E;
   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_NINE = 8'h39;
   localparam logic [7:0] CHAR_NUL  = 8'h00;

   localparam logic [1:0] FIELD_DAY  = 2'd0;
   localparam logic [1:0] FIELD_MON  = 2'd1;
   localparam logic [1:0] FIELD_YEAR = 2'd2;
   localparam logic [1:0] FIELD_PAST = 2'd3;

   localparam logic [2:0] ERR_NONE  = 3'd0;
   localparam logic [2:0] ERR_FIELD = 3'd1;
   localparam logic [2:0] ERR_YEAR  = 3'd2;
   localparam logic [2:0] ERR_MONTH = 3'd3;
   localparam logic [2:0] ERR_DAY   = 3'd4;

   localparam logic CSR_MIN_YEAR = 1'b0;
   localparam logic CSR_MAX_YEAR = 1'b1;

   localparam logic [VALUE_W-1:0] MIN_YEAR_RST = 14'd1900;
   localparam logic [VALUE_W-1:0] MAX_YEAR_RST = 14'd2099;

   // reciprocals: x/100 = (x*5243)>>19 for x < 32768, x/7 = (x*9363)>>16 for x < 2048
   localparam logic [12:0] RECIP_100 = 13'd5243;
   localparam logic [13:0] RECIP_7   = 14'd9363;

   typedef struct packed {
      logic [7:0] char_code;
      logic       last_char;
   } req_type;

   typedef struct packed {
      logic                date_ok;
      logic [2:0]          error_code;
      logic [4:0]          day_out;
      logic [3:0]          month_out;
      logic [VALUE_W-1:0]  year_out;
      logic [2:0]          weekday_out;
   } rsp_type;

   // one parsed text, handed from the parser to the checker
   typedef struct packed {
      logic                fld_err;
      logic [VALUE_W-1:0]  day_val;
      logic [VALUE_W-1:0]  mon_val;
      logic [VALUE_W-1:0]  yr_val;
   } parse_rec_type;

   function automatic logic [VALUE_W-1:0] sat_add_digit(input logic [VALUE_W-1:0] v,
                                                         input logic [3:0] d);
      logic [VALUE_W+3:0] n;
      n = {4'b0, v} * 18'd10 + {14'b0, d};
      return (n > {4'b0, VALUE_MAX}) ? VALUE_MAX : n[VALUE_W-1:0];
   endfunction

   // floor(2.6*m - 0.2) with march as month one
   function automatic logic [4:0] gauss_month_term(input logic [3:0] gm);
      logic [4:0] t;
      case (gm)
         4'd1:    t = 5'd2;
         4'd2:    t = 5'd5;
         4'd3:    t = 5'd7;
         4'd4:    t = 5'd10;
         4'd5:    t = 5'd12;
         4'd6:    t = 5'd15;
         4'd7:    t = 5'd18;
         4'd8:    t = 5'd20;
         4'd9:    t = 5'd23;
         4'd10:   t = 5'd25;
         4'd11:   t = 5'd28;
         4'd12:   t = 5'd31;
         default: t = 5'd0;
      endcase
      return t;
   endfunction

   function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
      logic [4:0] n;
      case (m)
         4'd4, 4'd6, 4'd9, 4'd11: n = 5'd30;
         4'd2:                    n = leap ? 5'd29 : 5'd28;
         default:                 n = 5'd31;
      endcase
      return n;
   endfunction

endpackage

`default_nettype wire

[rtl/dspw_front.sv]
`default_nettype none

module dspw_front
   import dspw_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_acc,
   input  wire req_type       req_data,
   output parse_rec_type      rec_out,
   output logic               rec_push
);

   logic [1:0]          field_idx_ff, field_idx_in;
   logic [VALUE_W-1:0]  day_ff, day_in;
   logic [VALUE_W-1:0]  mon_ff, mon_in;
   logic [VALUE_W-1:0]  yr_ff, yr_in;
   logic [2:0]          digit_seen_ff, digit_seen_in;
   logic [2:0]          bad_seen_ff, bad_seen_in;
   logic                ended_ff, ended_in;
   logic                is_digit;
   logic [3:0]          digit;

   assign is_digit = (req_data.char_code >= CHAR_ZERO) && (req_data.char_code <= CHAR_NINE);
   assign digit    = 4'(req_data.char_code - CHAR_ZERO);

   always_comb begin
      field_idx_in  = field_idx_ff;
      day_in        = day_ff;
      mon_in        = mon_ff;
      yr_in         = yr_ff;
      digit_seen_in = digit_seen_ff;
      bad_seen_in   = bad_seen_ff;
      ended_in      = ended_ff;
      rec_push      = 1'b0;
      rec_out       = '0;
      if (req_acc) begin
         if (!ended_ff) begin
            if (req_data.char_code == CHAR_NUL) begin
               ended_in = 1'b1;
            end else if (field_idx_ff != FIELD_PAST) begin
               if (req_data.char_code == CHAR_DOT) begin
                  field_idx_in = field_idx_ff + 2'd1;
               end else if (is_digit) begin
                  case (field_idx_ff)
                     FIELD_DAY: day_in = sat_add_digit(day_ff, digit);
                     FIELD_MON: mon_in = sat_add_digit(mon_ff, digit);
                     default:   yr_in  = sat_add_digit(yr_ff, digit);
                  endcase
                  digit_seen_in[field_idx_ff] = 1'b1;
               end else begin
                  bad_seen_in[field_idx_ff] = 1'b1;
               end
            end
         end
         if (req_data.last_char) begin
            rec_push        = 1'b1;
            rec_out.fld_err = (digit_seen_in != 3'b111) || (bad_seen_in != 3'b000);
            rec_out.day_val = day_in;
            rec_out.mon_val = mon_in;
            rec_out.yr_val  = yr_in;
            // back to a clean parse for the next text
            field_idx_in  = FIELD_DAY;
            day_in        = '0;
            mon_in        = '0;
            yr_in         = '0;
            digit_seen_in = '0;
            bad_seen_in   = '0;
            ended_in      = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         field_idx_ff  <= FIELD_DAY;
         day_ff        <= '0;
         mon_ff        <= '0;
         yr_ff         <= '0;
         digit_seen_ff <= '0;
         bad_seen_ff   <= '0;
         ended_ff      <= 1'b0;
      end else begin
         field_idx_ff  <= field_idx_in;
         day_ff        <= day_in;
         mon_ff        <= mon_in;
         yr_ff         <= yr_in;
         digit_seen_ff <= digit_seen_in;
         bad_seen_ff   <= bad_seen_in;
         ended_ff      <= ended_in;
      end
   end

endmodule

`default_nettype wire

[rtl/dspw_queue.sv]
`default_nettype none

module dspw_queue
   import dspw_pkg::*;
#(
   parameter int unsigned DEPTH = 2
)
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push,
   input  wire parse_rec_type push_data,
   input  wire logic          pop,
   output parse_rec_type      head_data,
   output logic               not_empty,
   output logic               full
);

   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   parse_rec_type       slot_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                do_push;
   logic                do_pop;

   assign not_empty = (count_ff != '0);
   assign full      = (count_ff == CNT_FULL);
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;
   assign head_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

[rtl/dspw_back.sv]
`default_nettype none

module dspw_back
   import dspw_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic [VALUE_W-1:0] min_year,
   input  wire logic [VALUE_W-1:0] max_year,
   input  wire parse_rec_type      head_data,
   input  wire logic               head_valid,
   output logic                    head_pop,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output rsp_type                 rsp_data
);

   logic                advance;

   // stage 1: divisions by 100
   logic                s1_vld_ff;
   parse_rec_type       s1_rec_ff;
   logic [7:0]          s1_qy_ff, s1_qy_in;
   logic [8:0]          s1_qg_ff, s1_qg_in;
   logic [VALUE_W:0]    s1_gy_ff, s1_gy_in;
   logic [3:0]          s1_gm_ff, s1_gm_in;
   logic                early;
   logic [26:0]         prod_y;
   logic [27:0]         prod_g;

   // stage 2: checks and gauss sum
   logic                s2_vld_ff;
   logic [2:0]          s2_err_ff, s2_err_in;
   logic [4:0]          s2_day_ff;
   logic [3:0]          s2_mon_ff;
   logic [VALUE_W-1:0]  s2_yr_ff;
   logic [10:0]         s2_sum_ff, s2_sum_in;
   logic [6:0]          rem_y;
   logic [6:0]          yy;
   logic                leap;
   logic [4:0]          mdays;

   // output stage: sum mod 7
   logic                out_vld_ff;
   rsp_type             out_ff, out_in;
   logic [24:0]         prod_7;
   logic [2:0]          wday;

   assign advance  = !(out_vld_ff && rsp_stall);
   assign head_pop = advance && head_valid;

   assign early    = (head_data.mon_val <= 14'd2);
   assign prod_y   = {13'b0, head_data.yr_val} * {14'b0, RECIP_100};
   assign s1_gy_in = {1'b0, head_data.yr_val} + 15'd400 - {14'b0, early};
   assign prod_g   = {13'b0, s1_gy_in} * {15'b0, RECIP_100};
   assign s1_qy_in = prod_y[26:19];
   assign s1_qg_in = prod_g[27:19];
   assign s1_gm_in = early ? 4'(head_data.mon_val + 14'd10) : 4'(head_data.mon_val - 14'd2);

   always_comb begin
      rem_y = 7'(s1_rec_ff.yr_val - ({6'b0, s1_qy_ff} * 14'd100));
      yy    = 7'(s1_gy_ff - ({6'b0, s1_qg_ff} * 15'd100));
      leap  = ((s1_rec_ff.yr_val[1:0] == 2'b00) && (rem_y != 7'd0)) ||
              ((rem_y == 7'd0) && (s1_qy_ff[1:0] == 2'b00));
      mdays = month_days(s1_rec_ff.mon_val[3:0], leap);
      if (s1_rec_ff.fld_err) begin
         s2_err_in = ERR_FIELD;
      end else if ((s1_rec_ff.yr_val < min_year) || (s1_rec_ff.yr_val > max_year)) begin
         s2_err_in = ERR_YEAR;
      end else if ((s1_rec_ff.mon_val == '0) || (s1_rec_ff.mon_val > 14'd12)) begin
         s2_err_in = ERR_MONTH;
      end else if ((s1_rec_ff.day_val == '0) ||
                   (s1_rec_ff.day_val > {9'b0, mdays})) begin
         s2_err_in = ERR_DAY;
      end else begin
         s2_err_in = ERR_NONE;
      end
      // only a valid date needs a correct sum, which stays below 2048
      s2_sum_in = 11'({6'b0, s1_rec_ff.day_val[4:0]})
                + 11'({6'b0, gauss_month_term(s1_gm_ff)})
                + 11'({4'b0, yy}) + 11'({6'b0, yy[6:2]})
                + 11'({4'b0, s1_qg_ff[8:2]})
                + 11'({2'b0, s1_qg_ff} * 11'd5);
   end

   always_comb begin
      prod_7 = {14'b0, s2_sum_ff} * {11'b0, RECIP_7};
      wday   = 3'(s2_sum_ff - ({2'b0, prod_7[24:16]} * 11'd7));
      out_in = '0;
      out_in.error_code = s2_err_ff;
      if (s2_err_ff == ERR_NONE) begin
         out_in.date_ok     = 1'b1;
         out_in.day_out     = s2_day_ff;
         out_in.month_out   = s2_mon_ff;
         out_in.year_out    = s2_yr_ff;
         out_in.weekday_out = (wday == 3'd0) ? 3'd7 : wday;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         s2_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else if (advance) begin
         s1_vld_ff  <= head_valid;
         s2_vld_ff  <= s1_vld_ff;
         out_vld_ff <= s2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_rec_ff <= head_data;
         s1_qy_ff  <= s1_qy_in;
         s1_qg_ff  <= s1_qg_in;
         s1_gy_ff  <= s1_gy_in;
         s1_gm_ff  <= s1_gm_in;
         s2_err_ff <= s2_err_in;
         s2_day_ff <= s1_rec_ff.day_val[4:0];
         s2_mon_ff <= s1_rec_ff.mon_val[3:0];
         s2_yr_ff  <= s1_rec_ff.yr_val;
         s2_sum_ff <= s2_sum_in;
         out_ff    <= out_in;
      end
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_ff;

   a_ok_has_weekday: assert property (@(posedge clock) disable iff (reset)
      (out_vld_ff && out_ff.date_ok) |->
         (out_ff.error_code == ERR_NONE) && (out_ff.weekday_out != 3'd0))
      else $error("valid date without weekday");

   a_bad_is_blank: assert property (@(posedge clock) disable iff (reset)
      (out_vld_ff && !out_ff.date_ok) |->
         (out_ff.error_code != ERR_NONE) && (out_ff.weekday_out == 3'd0) &&
         (out_ff.year_out == '0))
      else $error("invalid date carries fields");

   a_stage_moves: assert property (@(posedge clock) disable iff (reset)
      (s2_vld_ff && advance) |=> out_vld_ff)
      else $error("checked item lost before output");

   a_pop_feeds: assert property (@(posedge clock) disable iff (reset)
      head_pop |=> s1_vld_ff)
      else $error("popped item not in first stage");

endmodule

`default_nettype wire

[rtl/date_string_parse_weekday_top.sv]
// a text's record is queued at its last byte, then registered in stage 1, stage 2, output
// throughput: one byte per cycle; the front takes bytes while the checker pipeline holds
// a result, until the parsed-date queue (QUEUE_DEPTH entries) fills
// reset: synchronous, active high; clears the parser, queue and pipeline valids and sets
// min_year to 1900 and max_year to 2099
`default_nettype none

module date_string_parse_weekday_top
   import dspw_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = 2
)
(
   input  wire logic                clock,
   input  wire logic                reset,
   // byte stream
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire req_type             req_data,
   // one result per text
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output rsp_type                  rsp_data,
   // year bounds
   input  wire logic                csr_wr_en,
   input  wire logic                csr_addr,
   input  wire logic [VALUE_W-1:0]  csr_wdata
);

   logic [VALUE_W-1:0]  min_year_ff;
   logic [VALUE_W-1:0]  max_year_ff;
   logic                req_acc;
   parse_rec_type       rec;
   logic                rec_push;
   parse_rec_type       head;
   logic                head_valid;
   logic                head_pop;
   logic                queue_full;

   // config registers; the user must write them only while idle, the block does not enforce it
   always_ff @(posedge clock) begin
      if (reset) begin
         min_year_ff <= MIN_YEAR_RST;
         max_year_ff <= MAX_YEAR_RST;
      end else if (csr_wr_en) begin
         case (csr_addr)
            CSR_MIN_YEAR: min_year_ff <= csr_wdata;
            CSR_MAX_YEAR: max_year_ff <= csr_wdata;
            default:      min_year_ff <= min_year_ff;
         endcase
      end
   end

   // hold off bytes only while the queue has no room for a finished text
   assign req_stall = queue_full;
   assign req_acc   = req_valid && !req_stall;

   // front: splits fields and accumulates digits, one byte per transfer
   dspw_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_acc  (req_acc),
      .req_data (req_data),
      .rec_out  (rec),
      .rec_push (rec_push)
   );

   // short queue decouples the parser from a stalled result channel
   dspw_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rec_push),
      .push_data (rec),
      .pop       (head_pop),
      .head_data (head),
      .not_empty (head_valid),
      .full      (queue_full)
   );

   // back: range checks, leap year, gauss weekday, output register
   dspw_back u_back (
      .clock      (clock),
      .reset      (reset),
      .min_year   (min_year_ff),
      .max_year   (max_year_ff),
      .head_data  (head),
      .head_valid (head_valid),
      .head_pop   (head_pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule

`default_nettype wire

[dv/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
   import dspw_pkg::*;

   // ---------------------------------------------------------------
   // run limits and timing
   // ---------------------------------------------------------------
   localparam int unsigned CYCLE_LIMIT  = 400000;
   localparam int unsigned SETTLE_WAIT  = 8;     // settle margin, longer than the block's latency
   localparam int unsigned PHASE_BYTES  = 165;   // minimum random bytes per bounds setting
   localparam logic [7:0]  NUL_MARK     = 8'h23; // '#' in a directed text stands for a zero byte

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic          req_valid = 1'b0;
   logic          req_stall;
   req_type       req_data  = '0;
   logic          rsp_valid;
   logic          rsp_stall = 1'b0;
   rsp_type       rsp_data;
   logic          csr_wr_en = 1'b0;
   logic          csr_addr  = CSR_MIN_YEAR;
   logic [VALUE_W-1:0] csr_wdata = '0;

   date_string_parse_weekday_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   initial forever #6 clock = ~clock;

   // ---------------------------------------------------------------
   // date parser model: per-text parse state plus the year bounds
   // ---------------------------------------------------------------
   logic [1:0]         cur_field    = FIELD_DAY;
   logic [VALUE_W-1:0] day_acc      = '0;
   logic [VALUE_W-1:0] mon_acc      = '0;
   logic [VALUE_W-1:0] year_acc     = '0;
   logic [2:0]         digit_mask   = '0;
   logic [2:0]         bad_mask     = '0;
   logic               text_done    = 1'b0;
   logic [VALUE_W-1:0] cfg_min_year = MIN_YEAR_RST;
   logic [VALUE_W-1:0] cfg_max_year = MAX_YEAR_RST;

   // dates still owed by the block, oldest first
   rsp_type pending_dates[$];

   // directed texts can carry a hand-written answer instead of the model's
   bit      use_typed = 1'b0;
   rsp_type typed_rsp = '0;

   int unsigned error_count = 0;

   // random idling controls, in percent; request side per byte transfer, result side per stall draw
   int unsigned req_idle_pct = 0;
   int unsigned rsp_idle_pct = 0;
   int unsigned stall_left   = 0;

   // byte buffer of the text being sent
   logic [7:0] text_bytes[$];

   typedef struct {
      string   text;
      bit      typed;
      rsp_type want;
   } date_case_type;

   date_case_type date_cases[$];

   function automatic logic [VALUE_W-1:0] append_digit(input logic [VALUE_W-1:0] acc,
                                                       input logic [7:0] ch);
      int unsigned n;
      n = int'(acc) * 10 + (int'(ch) - int'(CHAR_ZERO));
      return (n > int'(VALUE_MAX)) ? VALUE_MAX : n[VALUE_W-1:0];
   endfunction

   function automatic bit is_leap(input int unsigned y);
      return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
   endfunction

   function automatic int unsigned days_in_month(input int unsigned m, input int unsigned y);
      case (m)
         4, 6, 9, 11: return 30;
         2:           return is_leap(y) ? 29 : 28;
         default:     return 31;
      endcase
   endfunction

   // gauss weekday, march as month one, year lifted by 400 to stay non-negative
   function automatic logic [2:0] gauss_weekday(input int unsigned d, input int unsigned m,
                                                input int unsigned y);
      int unsigned gm, gy, cent, yy, total;
      gm    = (m <= 2) ? m + 10 : m - 2;
      gy    = y + 400 - ((m <= 2) ? 1 : 0);
      cent  = gy / 100;
      yy    = gy % 100;
      total = d + (26 * gm - 2) / 10 + yy + yy / 4 + cent / 4 + 5 * cent;
      total = total % 7;
      return (total == 0) ? 3'd7 : total[2:0];
   endfunction

   // takes one byte into the parse state; returns 1 with the date on the final byte
   function automatic bit parse_date_byte(input req_type item, output rsp_type res);
      logic [2:0]  err;
      int unsigned d, m, y;
      res = '0;
      if (!text_done) begin
         if (item.char_code == CHAR_NUL) begin
            text_done = 1'b1;
         end else if (cur_field != FIELD_PAST) begin
            if (item.char_code == CHAR_DOT) begin
               cur_field = cur_field + 2'd1;
            end else if (item.char_code >= CHAR_ZERO && item.char_code <= CHAR_NINE) begin
               case (cur_field)
                  FIELD_DAY: day_acc  = append_digit(day_acc, item.char_code);
                  FIELD_MON: mon_acc  = append_digit(mon_acc, item.char_code);
                  default:   year_acc = append_digit(year_acc, item.char_code);
               endcase
               digit_mask[cur_field] = 1'b1;
            end else begin
               bad_mask[cur_field] = 1'b1;
            end
         end
      end
      if (!item.last_char) return 1'b0;

      d = day_acc;
      m = mon_acc;
      y = year_acc;
      if (digit_mask != 3'b111 || bad_mask != 3'b000)
         err = ERR_FIELD;
      else if (y < cfg_min_year || y > cfg_max_year)
         err = ERR_YEAR;
      else if (m < 1 || m > 12)
         err = ERR_MONTH;
      else if (d < 1 || d > days_in_month(m, y))
         err = ERR_DAY;
      else
         err = ERR_NONE;

      if (err == ERR_NONE) begin
         res.date_ok     = 1'b1;
         res.error_code  = ERR_NONE;
         res.day_out     = d[4:0];
         res.month_out   = m[3:0];
         res.year_out    = y[VALUE_W-1:0];
         res.weekday_out = gauss_weekday(d, m, y);
      end else begin
         res.error_code  = err;
      end

      // ready for the next text
      cur_field  = FIELD_DAY;
      day_acc    = '0;
      mon_acc    = '0;
      year_acc   = '0;
      digit_mask = '0;
      bad_mask   = '0;
      text_done  = 1'b0;
      return 1'b1;
   endfunction

   function automatic rsp_type date_rsp(input bit ok, input logic [2:0] err,
                                        input int unsigned d, input int unsigned m,
                                        input int unsigned y, input int unsigned w);
      rsp_type r;
      r.date_ok     = ok;
      r.error_code  = err;
      r.day_out     = d[4:0];
      r.month_out   = m[3:0];
      r.year_out    = y[VALUE_W-1:0];
      r.weekday_out = w[2:0];
      return r;
   endfunction

   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      if (error_count < 200)
         $display("mismatch %s: got %0d, expected %0d (t=%0t)", what, got, want, $realtime);
      error_count++;
   endtask

   task automatic add_case(input string text, input bit typed, input rsp_type want);
      date_case_type c;
      c.text  = text;
      c.typed = typed;
      c.want  = want;
      date_cases.push_back(c);
   endtask

   // ---------------------------------------------------------------
   // transfer monitor: predict on every accepted byte, check every result
   // ---------------------------------------------------------------
   always @(posedge clock) begin : check_transfers
      rsp_type predicted, wanted;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            if (parse_date_byte(req_data, predicted))
               pending_dates.push_back(use_typed ? typed_rsp : predicted);
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_dates.size() == 0) begin
               report_mismatch("result transfer with no date pending", 1, 0);
            end else begin
               wanted = pending_dates.pop_front();
               if (rsp_data.date_ok != wanted.date_ok)
                  report_mismatch("date_ok", rsp_data.date_ok, wanted.date_ok);
               if (rsp_data.error_code != wanted.error_code)
                  report_mismatch("error_code", rsp_data.error_code, wanted.error_code);
               if (rsp_data.day_out != wanted.day_out)
                  report_mismatch("day_out", rsp_data.day_out, wanted.day_out);
               if (rsp_data.month_out != wanted.month_out)
                  report_mismatch("month_out", rsp_data.month_out, wanted.month_out);
               if (rsp_data.year_out != wanted.year_out)
                  report_mismatch("year_out", rsp_data.year_out, wanted.year_out);
               if (rsp_data.weekday_out != wanted.weekday_out)
                  report_mismatch("weekday_out", rsp_data.weekday_out, wanted.weekday_out);
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // result side backpressure: stall bursts of random length
   // ---------------------------------------------------------------
   always @(negedge clock) begin
      if (stall_left != 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else if (rsp_idle_pct != 0 && $urandom_range(0, 99) < rsp_idle_pct) begin
         rsp_stall  <= 1'b1;
         stall_left <= $urandom_range(0, 7);
      end else begin
         rsp_stall  <= 1'b0;
      end
   end

   // ---------------------------------------------------------------
   // watchdog
   // ---------------------------------------------------------------
   initial begin : watchdog
      int unsigned cycle_count;
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("DONE: errors detected");
      $finish;
   end

   // one byte transfer, entered and left at a falling edge
   task automatic send_byte(input req_type item);
      if (req_idle_pct != 0 && $urandom_range(0, 99) < req_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   // sends text_bytes; last_char on the final byte, and at random inside noise
   task automatic send_text(input bit typed, input rsp_type want, input bit scatter);
      req_type item;
      use_typed = typed;
      typed_rsp = want;
      foreach (text_bytes[i]) begin
         item.char_code = text_bytes[i];
         if (i == text_bytes.size() - 1)
            item.last_char = 1'b1;
         else
            item.last_char = scatter && ($urandom_range(0, 3) == 0);
         send_byte(item);
      end
   endtask

   // decimal digits of a field, now and then with leading zeros
   task automatic append_number(input int unsigned v);
      logic [7:0] digs[$];
      if ($urandom_range(0, 7) == 0)
         repeat ($urandom_range(1, 2)) text_bytes.push_back(CHAR_ZERO);
      do begin
         digs.push_front(8'(int'(CHAR_ZERO) + v % 10));
         v = v / 10;
      end while (v != 0);
      foreach (digs[i]) text_bytes.push_back(digs[i]);
   endtask

   // random text: mostly well-formed dates near the edges, some broken, some noise
   task automatic build_random_text(output bit noisy);
      int unsigned kind, r, d, m, y, lo, hi, pos;
      logic [7:0]  junk;
      text_bytes.delete();
      kind  = $urandom_range(0, 9);
      noisy = (kind == 0);
      if (noisy) begin
         repeat ($urandom_range(1, 12)) text_bytes.push_back(8'($urandom_range(0, 255)));
      end else begin
         lo = (cfg_min_year < cfg_max_year) ? cfg_min_year : cfg_max_year;
         hi = (cfg_min_year < cfg_max_year) ? cfg_max_year : cfg_min_year;

         r = $urandom_range(0, 9);
         if (r < 6)       y = $urandom_range((lo > 2) ? lo - 2 : 0, hi + 2);
         else if (r < 8)  y = $urandom_range(0, 16383);
         else if (r == 8) y = $urandom_range(16384, 99999);  // saturates
         else             y = $urandom_range(0, 99);

         m = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 12) : $urandom_range(0, 20);

         r = $urandom_range(0, 9);
         if (r < 5)       d = $urandom_range(1, 28);
         else if (r < 8)  d = days_in_month(m, y) + $urandom_range(0, 1);  // month edge
         else if (r == 8) d = $urandom_range(0, 99);
         else             d = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(16383, 200000);

         append_number(d);
         text_bytes.push_back(CHAR_DOT);
         append_number(m);
         text_bytes.push_back(CHAR_DOT);
         append_number(y);
         // tail past the third separator
         if ($urandom_range(0, 9) == 0) begin
            text_bytes.push_back(CHAR_DOT);
            repeat ($urandom_range(0, 4)) text_bytes.push_back(8'($urandom_range(0, 255)));
         end

         if (kind == 1) begin
            pos = $urandom_range(0, text_bytes.size() - 1);
            case ($urandom_range(0, 3))
               0: begin
                  do junk = 8'($urandom_range(1, 255));
                  while ((junk >= CHAR_ZERO && junk <= CHAR_NINE) || junk == CHAR_DOT);
                  text_bytes[pos] = junk;
               end
               1: text_bytes.delete(pos);
               2: text_bytes.insert(pos, CHAR_DOT);
               default: text_bytes.insert(pos, CHAR_NUL);
            endcase
         end
      end
   endtask

   // both bounds in back-to-back writes, enable held across them
   task automatic set_year_bounds(input int unsigned lo, input int unsigned hi);
      csr_wr_en <= 1'b1;
      csr_addr  <= CSR_MIN_YEAR;
      csr_wdata <= lo[VALUE_W-1:0];
      cfg_min_year = lo[VALUE_W-1:0];
      @(negedge clock);
      csr_addr  <= CSR_MAX_YEAR;
      csr_wdata <= hi[VALUE_W-1:0];
      cfg_max_year = hi[VALUE_W-1:0];
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // nothing owed, then let the pipeline settle
   task automatic wait_idle();
      while (pending_dates.size() != 0) @(posedge clock);
      repeat (SETTLE_WAIT) @(negedge clock);
   endtask

   // ---------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------
   initial begin : stimulus
      logic [7:0]  ch;
      int unsigned sent, lo, hi;
      bit          noisy;

      // directed texts at the reset bounds 1900..2099
      add_case("15.6.2024",      1'b0, '0);
      add_case("1.1.1900",       1'b1, date_rsp(1, ERR_NONE, 1, 1, 1900, 1));
      add_case("31.12.2099",     1'b0, '0);
      add_case("1.1.2000#",      1'b1, date_rsp(1, ERR_NONE, 1, 1, 2000, 6));
      add_case("31.12.1899",     1'b1, date_rsp(0, ERR_YEAR, 0, 0, 0, 0));
      add_case("1.1.2100",       1'b1, date_rsp(0, ERR_YEAR, 0, 0, 0, 0));
      add_case("1.1.99999",      1'b1, date_rsp(0, ERR_YEAR, 0, 0, 0, 0));
      add_case("1.0.2000",       1'b1, date_rsp(0, ERR_MONTH, 0, 0, 0, 0));
      add_case("1.13.2000",      1'b1, date_rsp(0, ERR_MONTH, 0, 0, 0, 0));
      add_case("0.5.2020",       1'b1, date_rsp(0, ERR_DAY, 0, 0, 0, 0));
      add_case("31.4.2020",      1'b1, date_rsp(0, ERR_DAY, 0, 0, 0, 0));
      add_case("29.2.2023",      1'b1, date_rsp(0, ERR_DAY, 0, 0, 0, 0));
      add_case("29.2.1900",      1'b1, date_rsp(0, ERR_DAY, 0, 0, 0, 0));
      add_case("29.2.2000",      1'b0, '0);
      add_case("29.2.2024",      1'b0, '0);
      add_case("99999.1.2000",   1'b1, date_rsp(0, ERR_DAY, 0, 0, 0, 0));
      add_case("..2000",         1'b1, date_rsp(0, ERR_FIELD, 0, 0, 0, 0));
      add_case("1.1",            1'b1, date_rsp(0, ERR_FIELD, 0, 0, 0, 0));
      add_case("1a.1.2000",      1'b1, date_rsp(0, ERR_FIELD, 0, 0, 0, 0));
      add_case("#",              1'b1, date_rsp(0, ERR_FIELD, 0, 0, 0, 0));
      add_case("1.1.2000.9x.7",  1'b1, date_rsp(1, ERR_NONE, 1, 1, 2000, 6));
      add_case("1.1.2000.",      1'b1, date_rsp(1, ERR_NONE, 1, 1, 2000, 6));
      add_case("2.3.2021#7.z.",  1'b0, '0);
      add_case("007.03.02021",   1'b0, '0);

      // reset held, then released on a falling edge
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      req_idle_pct = 20;
      rsp_idle_pct = 20;
      foreach (date_cases[k]) begin
         text_bytes.delete();
         for (int i = 0; i < date_cases[k].text.len(); i++) begin
            ch = date_cases[k].text[i];
            text_bytes.push_back((ch == NUL_MARK) ? CHAR_NUL : ch);
         end
         send_text(date_cases[k].typed, date_cases[k].want, 1'b0);
      end

      // random phases over a spread of year bounds; the last one without idling
      for (int p = 0; p < 6; p++) begin
         case (p)
            0: begin lo = 0;    hi = 9999; end
            1: begin lo = 9999; hi = 0;    end  // inverted bounds, every year fails
            2: begin lo = 0;    hi = 0;    end
            3: begin lo = 9999; hi = 9999; end
            4: begin
               lo = $urandom_range(0, 9999);
               hi = $urandom_range(lo, 9999);
            end
            default: begin
               lo = $urandom_range(0, 2000);
               hi = $urandom_range(2000, 9999);
            end
         endcase
         req_valid <= 1'b0;
         wait_idle();
         set_year_bounds(lo, hi);

         if (p == 5) begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end else begin
            case ($urandom_range(0, 3))
               0: req_idle_pct = 0;
               1: req_idle_pct = 10;
               2: req_idle_pct = 30;
               default: req_idle_pct = 60;
            endcase
            rsp_idle_pct = $urandom_range(0, 3) * 15;
         end

         sent = 0;
         while (sent < PHASE_BYTES) begin
            build_random_text(noisy);
            send_text(1'b0, '0, noisy);
            sent += text_bytes.size();
         end
      end

      // drain and final verdict
      req_valid <= 1'b0;
      wait_idle();
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
